[design/sdtq_pkg.sv]
package sdtq_pkg;

  localparam int CAPACITY     = 16;
  localparam int HANDLE_COUNT = 64;
  localparam int ADDR_W       = $clog2(CAPACITY);
  localparam int CNT_W        = $clog2(CAPACITY + 1);
  localparam int HANDLE_W     = 6;
  localparam int TIME_W       = 32;

  // Forward distances below this value count as "before" on the wrapping clock.
  localparam logic [TIME_W-1:0] HALF_RANGE = 32'h7FFF_FFFF;

  localparam int IN_RAW  = 2 + HANDLE_W + TIME_W + TIME_W;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;
  localparam int OUT_RAW = 2 + 1 + 1 + HANDLE_W + TIME_W + CNT_W;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  typedef enum logic [1:0] {
    OP_REGISTER   = 2'd0,
    OP_UNREGISTER = 2'd1,
    OP_CHECK      = 2'd2,
    OP_FIRST      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOT_REG = 2'd2,
    ST_ALREADY = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_CHECK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PLACE,
    S_DROP,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   deadline;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } tbl_ctl_t;

endpackage

[design/sorted_deadline_timer_queue_core.sv]
// Channel  Direction  Handshake            Payload
// s_*      in         s_tvalid / s_tready  operation, handle, deadline, now_time
// m_*      out        m_tvalid / m_tready  status, expired, head fields, entry_count
//
// Each request first scans the stored entries, then, where needed, opens or closes
// a gap by moving entries one at a time. The search and every entry moved take a
// read and then a compare or write step each, through the one read port and one
// write port of the entry store; the search and the expiry check share the one
// wrap-around comparator.
// Reset is synchronous and empties the queue at once; no clearing pass is needed.
// The input is taken only when the sequencer is idle; a finished result waits in the
// output register, and a new request is accepted while it is still waiting.
module sorted_deadline_timer_queue_core (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // operation[1:0], handle[7:2], deadline[39:8], now_time[71:40]
  input  logic [sdtq_pkg::IN_W-1:0]  s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // status[1:0], expired[2], head_valid[3], head_handle[9:4], head_deadline[41:10],
  // entry_count[46:42], zero padding above
  output logic [sdtq_pkg::OUT_W-1:0] m_tdata
);
  import sdtq_pkg::*;

  state_t state, state_next;

  // Request held for the whole operation.
  op_t                 req_op;
  logic [HANDLE_W-1:0] req_handle;
  logic [TIME_W-1:0]   req_dl;
  logic [TIME_W-1:0]   req_now;

  // Sequencer bookkeeping.
  logic [CNT_W-1:0]  idx;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  idx_dec;
  logic [CNT_W-1:0]  idx_inc2;
  logic [CNT_W-1:0]  pos;
  logic [CNT_W-1:0]  pos_inc;
  logic [CNT_W-1:0]  ins_pos;
  logic [CNT_W-1:0]  count;
  logic              found;
  logic              ins_set;
  logic              shift_up;
  logic [TIME_W-1:0] found_dl;
  status_t           status_r;
  logic              expired_r;
  entry_t            head_entry;

  logic              known;
  logic              present;
  logic              full;

  tbl_ctl_t          tbl_ctl;
  entry_t            rdata;

  logic [TIME_W-1:0] unit_a;
  logic [TIME_W-1:0] unit_b;
  logic              unit_before;

  logic              head_valid;
  logic [OUT_RAW-1:0] result_raw;

  sdtq_table u_table (
    .clk   (clk),
    .ctl   (tbl_ctl),
    .rdata (rdata)
  );

  sdtq_cmp u_cmp (
    .a         (unit_a),
    .b         (unit_b),
    .is_before (unit_before)
  );

  assign idx_inc  = idx + CNT_W'(1);
  assign idx_dec  = idx - CNT_W'(1);
  assign idx_inc2 = idx + CNT_W'(2);
  assign pos_inc  = pos + CNT_W'(1);
  assign known    = (32'(req_handle) < HANDLE_COUNT);
  assign present  = found && known;
  assign full     = (32'(count) >= CAPACITY);

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (count == '0) ? S_DECIDE : S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        state_next = (idx_inc == count) ? S_DECIDE : S_SCAN_RD;
      end
      S_DECIDE: begin
        unique case (req_op)
          OP_REGISTER: begin
            if (!known || found || full) begin
              state_next = S_DONE;
            end else if (ins_pos == count) begin
              state_next = S_PLACE;
            end else begin
              state_next = S_SHIFT_RD;
            end
          end
          OP_UNREGISTER: begin
            if (!present) begin
              state_next = S_DONE;
            end else if (pos_inc == count) begin
              state_next = S_DROP;
            end else begin
              state_next = S_SHIFT_RD;
            end
          end
          OP_CHECK: begin
            state_next = present ? S_CHECK : S_DONE;
          end
          OP_FIRST: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_CHECK: begin
        // The entry has expired once now is no longer before its deadline.
        if (unit_before) begin
          state_next = S_DONE;
        end else if (pos_inc == count) begin
          state_next = S_DROP;
        end else begin
          state_next = S_SHIFT_RD;
        end
      end
      S_SHIFT_RD: begin
        state_next = S_SHIFT_WR;
      end
      S_SHIFT_WR: begin
        if (shift_up) begin
          state_next = (idx_dec == ins_pos) ? S_PLACE : S_SHIFT_RD;
        end else begin
          state_next = (idx_inc2 == count) ? S_DROP : S_SHIFT_RD;
        end
      end
      S_PLACE: begin
        state_next = S_DONE;
      end
      S_DROP: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control outputs of the sequencer: store ports and comparator operands.
  always_comb begin
    s_tready        = (state == S_IDLE);
    tbl_ctl         = '0;
    unit_a          = rdata.deadline;
    unit_b          = req_dl;
    unique case (state)
      S_SCAN_RD: begin
        tbl_ctl.raddr = idx[ADDR_W-1:0];
      end
      S_SHIFT_RD: begin
        // Opening a gap reads the entry below; closing one reads the entry above.
        tbl_ctl.raddr = shift_up ? idx_dec[ADDR_W-1:0] : idx_inc[ADDR_W-1:0];
      end
      S_SHIFT_WR: begin
        tbl_ctl.we    = 1'b1;
        tbl_ctl.waddr = idx[ADDR_W-1:0];
        tbl_ctl.wdata = rdata;
      end
      S_PLACE: begin
        tbl_ctl.we             = 1'b1;
        tbl_ctl.waddr          = ins_pos[ADDR_W-1:0];
        tbl_ctl.wdata.handle   = req_handle;
        tbl_ctl.wdata.deadline = req_dl;
      end
      S_CHECK: begin
        unit_a = req_now;
        unit_b = found_dl;
      end
      default: begin
      end
    endcase
  end

  assign head_valid = (count != '0);
  assign result_raw = {count,
                       head_valid ? head_entry.deadline : TIME_W'(0),
                       head_valid ? head_entry.handle : HANDLE_W'(0),
                       head_valid, expired_r, status_r};

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == S_PLACE) begin
        count <= count + CNT_W'(1);
      end else if (state == S_DROP) begin
        count <= count - CNT_W'(1);
      end
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    // Slot zero is mirrored so that the head is always at hand for the result.
    if (tbl_ctl.we && tbl_ctl.waddr == '0) begin
      head_entry <= tbl_ctl.wdata;
    end
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          req_op     <= op_t'(s_tdata[1:0]);
          req_handle <= s_tdata[7:2];
          req_dl     <= s_tdata[39:8];
          req_now    <= s_tdata[71:40];
          idx        <= '0;
          found      <= 1'b0;
          ins_set    <= 1'b0;
          ins_pos    <= count;
          status_r   <= ST_OK;
          expired_r  <= 1'b0;
        end
      end
      S_SCAN_CMP: begin
        if (!found && rdata.handle == req_handle) begin
          found    <= 1'b1;
          pos      <= idx;
          found_dl <= rdata.deadline;
        end
        // A new entry goes in front of the first one it is not behind.
        if (!ins_set && !unit_before) begin
          ins_set <= 1'b1;
          ins_pos <= idx;
        end
        idx <= idx_inc;
      end
      S_DECIDE: begin
        case (req_op)
          OP_REGISTER: begin
            if (!known) begin
              status_r <= ST_NOT_REG;
            end else if (found) begin
              status_r <= ST_ALREADY;
            end else if (full) begin
              status_r <= ST_FULL;
            end else begin
              idx      <= count;
              shift_up <= 1'b1;
            end
          end
          OP_UNREGISTER, OP_CHECK: begin
            if (!present) begin
              status_r <= ST_NOT_REG;
            end else begin
              idx      <= pos;
              shift_up <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end
      S_CHECK: begin
        if (!unit_before) begin
          expired_r <= 1'b1;
        end
      end
      S_SHIFT_WR: begin
        idx <= shift_up ? idx_dec : idx_inc;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= OUT_W'(result_raw);
        end
      end
      default: begin
      end
    endcase
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    32'(count) <= CAPACITY)
    else $error("entry count above capacity");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !tbl_ctl.we)
    else $error("store written while idle");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == S_DONE)
    else $error("result raised outside completion");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && count != $past(count)) |->
      (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1)))
    else $error("entry count moved by more than one");

endmodule

[design/sdtq_cmp.sv]
// Wrap-around time compare: a is before b when (b - a) mod 2^32 is below half range.
module sdtq_cmp (
  input  logic [sdtq_pkg::TIME_W-1:0] a,
  input  logic [sdtq_pkg::TIME_W-1:0] b,
  output logic                        is_before
);
  import sdtq_pkg::*;

  logic [TIME_W-1:0] diff;

  assign diff      = b - a;
  assign is_before = (diff < HALF_RANGE);

endmodule

[design/sdtq_table.sv]
// Sorted entry store: one write port, one read port with registered data.
module sdtq_table (
  input  logic                clk,
  input  sdtq_pkg::tbl_ctl_t  ctl,
  output sdtq_pkg::entry_t    rdata
);
  import sdtq_pkg::*;

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata <= mem[ctl.raddr];
  end

endmodule

[dv/tb.sv]
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtq_pkg::*;

  // The run is stopped here if the block hangs. Even the slowest correct run, with
  // every request searching and shifting a full table behind long stalls on both
  // sides, stays far below this figure.
  localparam int CYCLE_LIMIT   = 600_000;
  localparam int ITEMS_PER_RUN = 190;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 100;

  // One reply of the block, in the order its fields sit in m_tdata.
  typedef struct packed {
    logic [CNT_W-1:0]    entry_count;
    logic [TIME_W-1:0]   head_deadline;
    logic [HANDLE_W-1:0] head_handle;
    logic                head_valid;
    logic                expired;
    status_t             status;
  } timer_reply_t;

  // Shadow of the sorted table. It follows every accepted request and keeps the
  // replies that the block owes, oldest first.
  class deadline_table;
    bit [TIME_W-1:0]   entry_dl[CAPACITY];
    bit [HANDLE_W-1:0] entry_id[CAPACITY];
    int                fill;
    timer_reply_t      awaited_replies[$];
    int                failures;

    // True when time a lies before time b on the wrapping millisecond clock.
    function bit precedes(bit [TIME_W-1:0] a, bit [TIME_W-1:0] b);
      bit [TIME_W-1:0] gap;
      gap = b - a;
      return gap < HALF_RANGE;
    endfunction

    function void drop_entry(int at);
      for (int i = at; i + 1 < fill; i++) begin
        entry_dl[i] = entry_dl[i + 1];
        entry_id[i] = entry_id[i + 1];
      end
      fill--;
    endfunction

    function void note_request(op_t op, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] dl,
                               logic [TIME_W-1:0] now);
      timer_reply_t r;
      int           at;
      int           slot;
      bit           present;
      r = '0;
      r.status = ST_OK;
      slot = fill;
      for (int i = 0; i < fill; i++) begin
        if (entry_id[i] == h && slot == fill) slot = i;
      end
      present = (h < HANDLE_COUNT) && (slot < fill);
      case (op)
        OP_REGISTER: begin
          if (h >= HANDLE_COUNT) r.status = ST_NOT_REG;
          else if (present) r.status = ST_ALREADY;
          else if (fill >= CAPACITY) r.status = ST_FULL;
          else begin
            // A new entry goes behind every stored entry that is not later than it.
            at = 0;
            while (at < fill && precedes(entry_dl[at], dl)) at++;
            for (int i = fill; i > at; i--) begin
              entry_dl[i] = entry_dl[i - 1];
              entry_id[i] = entry_id[i - 1];
            end
            entry_dl[at] = dl;
            entry_id[at] = h;
            fill++;
          end
        end
        OP_UNREGISTER: begin
          if (!present) r.status = ST_NOT_REG;
          else drop_entry(slot);
        end
        OP_CHECK: begin
          if (!present) r.status = ST_NOT_REG;
          else if (!precedes(now, entry_dl[slot])) begin
            drop_entry(slot);
            r.expired = 1'b1;
          end
        end
        default: ;
      endcase
      if (fill > 0) begin
        r.head_valid    = 1'b1;
        r.head_handle   = entry_id[0];
        r.head_deadline = entry_dl[0];
      end
      r.entry_count = CNT_W'(fill);
      awaited_replies.push_back(r);
    endfunction

    function void check_reply(logic [OUT_W-1:0] d);
      timer_reply_t want;
      timer_reply_t got;
      if (awaited_replies.size() == 0) begin
        $error("reply with no request outstanding: %h", d);
        failures++;
        return;
      end
      want = awaited_replies.pop_front();
      got  = d[OUT_RAW-1:0];
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        failures++;
      end
      if (got.expired !== want.expired) begin
        $error("expired: expected %0d, got %0d", want.expired, got.expired);
        failures++;
      end
      if (got.head_valid !== want.head_valid) begin
        $error("head_valid: expected %0d, got %0d", want.head_valid, got.head_valid);
        failures++;
      end
      if (got.head_handle !== want.head_handle) begin
        $error("head_handle: expected %0d, got %0d", want.head_handle, got.head_handle);
        failures++;
      end
      if (got.head_deadline !== want.head_deadline) begin
        $error("head_deadline: expected %h, got %h", want.head_deadline, got.head_deadline);
        failures++;
      end
      if (got.entry_count !== want.entry_count) begin
        $error("entry_count: expected %0d, got %0d", want.entry_count, got.entry_count);
        failures++;
      end
    endfunction
  endclass

  logic             clk      = 1'b0;
  logic             rst      = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata  = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  deadline_table    table_shadow = new;

  // Idling odds in percent, a long hold-off of the receiver on request, and the
  // running millisecond time around which random deadlines are placed.
  int               send_idle_pct = 37;
  int               recv_idle_pct = 79;
  int               fill_bias     = 50;
  bit               hold_req;
  int               hold_left;
  int               cycle_count;
  logic [TIME_W-1:0] clock_ms;

  sorted_deadline_timer_queue_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // Every process below wakes on the rising edge and reads the block's outputs
  // before any of that edge's updates land, so what it sees is what the edge saw.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        table_shadow.note_request(op_t'(s_tdata[1:0]), s_tdata[7:2], s_tdata[39:8],
                                  s_tdata[71:40]);
      end
      if (m_tvalid && m_tready) table_shadow.check_reply(m_tdata);
    end
  end

  // The receiver. A hold-off request keeps tready low for a long stretch so that
  // a finished reply sits in the output register and the input backs up behind it.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Offers one request, with random idle cycles in front of it, and returns at the
  // edge where it was taken. tvalid stays high afterwards so that the next request
  // can follow back to back.
  task automatic send_request(op_t op, logic [HANDLE_W-1:0] h, logic [TIME_W-1:0] dl,
                              logic [TIME_W-1:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {now, dl, h, op};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops offering and waits until every reply owed has come back. The first edge
  // lets the monitor record a request taken at the very edge this task starts on.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (table_shadow.awaited_replies.size() != 0) @(posedge clk);
  endtask

  // Most requests form sensible sequences: handles drawn from a small pool so that
  // they collide, deadlines near the running time, and checks and removals aimed at
  // handles that are actually queued. The rest is noise over the whole field range.
  task automatic random_request();
    int                  pick;
    int                  idx;
    op_t                 op;
    logic [HANDLE_W-1:0] h;
    logic [TIME_W-1:0]   dl;
    logic [TIME_W-1:0]   now;
    h        = HANDLE_W'($urandom_range(0, 23));
    dl       = $urandom();
    now      = $urandom();
    clock_ms = clock_ms + $urandom_range(0, 20);
    idx      = (table_shadow.fill > 0) ? $urandom_range(0, table_shadow.fill - 1) : 0;
    if ($urandom_range(0, 99) < fill_bias) begin
      op = OP_REGISTER;
      if ($urandom_range(0, 99) < 15) h = HANDLE_W'($urandom_range(0, 63));
      pick = $urandom_range(0, 99);
      if (pick < 60) dl = clock_ms + $urandom_range(0, 300);
      else if (pick < 75 && table_shadow.fill > 0) dl = table_shadow.entry_dl[idx];
      else if (pick < 85) dl = clock_ms - $urandom_range(0, 300);
    end else begin
      pick = $urandom_range(0, 9);
      op = (pick < 5) ? OP_CHECK : (pick < 8) ? OP_UNREGISTER : OP_FIRST;
      if (op != OP_FIRST && table_shadow.fill > 0 && $urandom_range(0, 99) < 85) begin
        h = table_shadow.entry_id[idx];
      end
      if (op == OP_CHECK) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) now = clock_ms;
        // Right at the deadline: one before, equal, one after.
        else if (pick < 8) now = table_shadow.entry_dl[idx] + $urandom_range(0, 2) - 1;
        // Half a wrap away, where the ordering flips.
        else if (pick < 9) now = table_shadow.entry_dl[idx] - HALF_RANGE + $urandom_range(0, 1);
      end
    end
    send_request(op, h, dl, now);
  endtask

  initial begin
    clock_ms = $urandom();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening. The head on an empty table, requests for absent handles,
    // both ends of the time range with a wrap between them, a duplicate register,
    // an equal deadline that must queue behind its twin, checks just before, at and
    // just past a deadline, the half-wrap boundary, and finally an overflow.
    send_request(OP_FIRST, 6'd0, 32'h0, 32'h0);
    send_request(OP_CHECK, 6'd7, 32'h0, 32'h0);
    send_request(OP_UNREGISTER, 6'd7, 32'h0, 32'h0);
    send_request(OP_REGISTER, 6'd63, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_REGISTER, 6'd0, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_REGISTER, 6'd63, 32'd5, 32'h0);
    send_request(OP_REGISTER, 6'd5, 32'hFFFF_FFFF, 32'h0);
    send_request(OP_CHECK, 6'd5, 32'h0, 32'hFFFF_FFFE);
    send_request(OP_CHECK, 6'd5, 32'h0, 32'hFFFF_FFFF);
    send_request(OP_CHECK, 6'd5, 32'h0, 32'h0);
    send_request(OP_CHECK, 6'd63, 32'h0, 32'h8000_0001);
    send_request(OP_CHECK, 6'd63, 32'h0, 32'h8000_0000);
    for (int i = 0; i < CAPACITY - 1; i++) begin
      send_request(OP_REGISTER, HANDLE_W'(20 + i), TIME_W'(5000 - 100 * i), 32'h0);
    end
    send_request(OP_REGISTER, 6'd40, 32'd100, 32'h0);
    wait_drained();

    // Three random stretches: a slow receiver, then a slow sender, then neither.
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 37 : (phase == 1) ? 79 : 0;
      recv_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 37 : 0;
      for (int n = 0; n < ITEMS_PER_RUN; n++) begin
        // Swing between filling and draining.
        if (n % 50 == 0) fill_bias = $urandom_range(0, 1) ? 60 : 25;
        if (phase == 1 && n == 100) wait_drained();
        if (phase == 2 && n == 60) hold_req = 1'b1;
        random_request();
      end
      wait_drained();
    end

    // Anything the block sends after this point has no request behind it.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (table_shadow.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
